FILE: rtl/core/line_raster_stepper_core_assert.svh
// Assertion macros for the line raster stepper checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef LINE_RASTER_STEPPER_CORE_ASSERT_SVH
`define LINE_RASTER_STEPPER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("lrs assertion failed");

// Next-cycle implication, checked outside reset.
`define LRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("lrs assertion failed");

`endif

FILE: rtl/core/lrs_pkg.sv
// Types and constants for the line raster stepper.
// No dependencies; used by the core and its checker.
`default_nettype none

package lrs_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAME_BITS = COORD_BITS + 1;
    localparam int DEC_BITS   = COORD_BITS + 3;
    localparam int CALC_BITS  = COORD_BITS + 4;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_NEXT = 1'b1
    } t_op;

    typedef struct packed {
        logic back;
        logic neg;
        logic swap;
    } t_mode;

    typedef struct packed {
        t_op                           op;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  point_x;
        logic signed [COORD_BITS-1:0]  point_y;
        logic                          point_valid;
        logic                          last_point;
        logic        [COORD_BITS-1:0]  cell_count;
    } t_out_item;

endpackage

`default_nettype wire

FILE: rtl/core/line_raster_stepper_core.sv
// Line raster stepper: Bresenham line walker over all octants.
// Depends on lrs_pkg for the item types and width constants.
//
// Usage:
//   Input channel i_valid/i_item/o_stall, output channel o_valid/o_item/i_stall.
//   A load item (op = OP_LOAD) sets up a line from start to end and returns
//   the number of cells it will emit in cell_count (0 when start equals end).
//   Each next item (op = OP_NEXT) returns one cell, start excluded, end
//   included, with last_point on the end cell. A next item with no line
//   loaded, or after the end cell, returns an all-zero item.
//   Registered result: o_valid rises in the cycle after accept. One item per cycle
//   unless stalled; the step is one add and compare on the stored decision term.
//   The result register frees as it is taken, so a new item is accepted in
//   the same cycle the previous result leaves.
//   Stall: while o_valid is high and i_stall is high, o_item holds and
//   o_stall is raised, so no further item is taken.
//   Reset: synchronous, active low; clears the output valid and drops any
//   loaded line.
`default_nettype none

module line_raster_stepper_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire lrs_pkg::t_in_item  i_item,
    output logic                  o_stall,
    output logic                  o_valid,
    output lrs_pkg::t_out_item    o_item,
    input  wire logic             i_stall
);

    localparam int CW = lrs_pkg::COORD_BITS;
    localparam int FW = lrs_pkg::FRAME_BITS;
    localparam int DB = lrs_pkg::DEC_BITS;
    localparam int KW = lrs_pkg::CALC_BITS;

    logic                    r_active, n_active;
    logic [CW-1:0]           r_left, n_left;
    logic signed [FW-1:0]    r_major, n_major;
    logic signed [FW-1:0]    r_minor, n_minor;
    logic signed [DB-1:0]    r_dec, n_dec;
    logic [CW-1:0]           r_du, n_du;
    logic [CW-1:0]           r_dv, n_dv;
    lrs_pkg::t_mode          r_mode, n_mode;
    logic                    r_out_valid, n_out_valid;
    lrs_pkg::t_out_item      r_out, n_out;

    logic                    accept;
    // load path
    logic signed [FW-1:0]    sx, sy, ex, ey, dx, dy, adx, ady, yn0, ud;
    logic [CW-1:0]           du, dv;
    logic                    swap, neg;
    // step path
    logic signed [KW-1:0]    d, two_dv, two_du, a, nd;
    logic signed [FW-1:0]    nmaj, nmin, xs, yns, ys;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        sx  = FW'(i_item.start_x);
        sy  = FW'(i_item.start_y);
        ex  = FW'(i_item.end_x);
        ey  = FW'(i_item.end_y);
        dx  = ex - sx;
        dy  = ey - sy;
        adx = dx[FW-1] ? -dx : dx;
        ady = dy[FW-1] ? -dy : dy;
        swap = ady > adx;
        neg  = (dx != '0) && (dy != '0) && (dx[FW-1] != dy[FW-1]);
        du   = swap ? ady[CW-1:0] : adx[CW-1:0];
        dv   = swap ? adx[CW-1:0] : ady[CW-1:0];
        yn0  = neg ? -sy : sy;
        ud   = swap ? (neg ? -dy : dy) : dx;

        two_dv = KW'({r_dv, 1'b0});
        two_du = KW'({r_du, 1'b0});
        d      = KW'(r_dec);
        a      = d - two_dv;
        if (r_mode.back) begin
            nmaj = r_major - FW'(1);
            if (a > (two_dv - two_du)) begin
                nd   = a;
                nmin = r_minor;
            end else begin
                nd   = a + two_du;
                nmin = r_minor - FW'(1);
            end
        end else begin
            nmaj = r_major + FW'(1);
            if (d > KW'(0)) begin
                nd   = d + two_dv - two_du;
                nmin = r_minor + FW'(1);
            end else begin
                nd   = d + two_dv;
                nmin = r_minor;
            end
        end
        xs  = r_mode.swap ? nmin : nmaj;
        yns = r_mode.swap ? nmaj : nmin;
        ys  = r_mode.neg ? -yns : yns;
    end

    always_comb begin
        n_active = r_active;
        n_left   = r_left;
        n_major  = r_major;
        n_minor  = r_minor;
        n_dec    = r_dec;
        n_du     = r_du;
        n_dv     = r_dv;
        n_mode   = r_mode;
        n_out    = r_out;
        n_out_valid = r_out_valid && i_stall;
        if (accept) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            unique case (i_item.op)
                lrs_pkg::OP_LOAD: begin
                    n_active = 1'b0;
                    n_left   = '0;
                    if ((dx != '0) || (dy != '0)) begin
                        n_active    = 1'b1;
                        n_left      = du;
                        n_du        = du;
                        n_dv        = dv;
                        n_major     = swap ? yn0 : sx;
                        n_minor     = swap ? sx : yn0;
                        n_dec       = DB'(KW'({dv, 1'b0}) - KW'(du));
                        n_mode.swap = swap;
                        n_mode.neg  = neg;
                        n_mode.back = ud[FW-1];
                        n_out.cell_count = du;
                    end
                end
                lrs_pkg::OP_NEXT: begin
                    if (r_active) begin
                        n_major = nmaj;
                        n_minor = nmin;
                        n_dec   = DB'(nd);
                        n_left  = r_left - CW'(1);
                        n_out.point_x     = xs[CW-1:0];
                        n_out.point_y     = ys[CW-1:0];
                        n_out.point_valid = 1'b1;
                        if (r_left == CW'(1)) begin
                            n_out.last_point = 1'b1;
                            n_active         = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_left      <= '0;
            r_major     <= '0;
            r_minor     <= '0;
            r_dec       <= '0;
            r_du        <= '0;
            r_dv        <= '0;
            r_mode      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_left      <= n_left;
            r_major     <= n_major;
            r_minor     <= n_minor;
            r_dec       <= n_dec;
            r_du        <= n_du;
            r_dv        <= n_dv;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

`default_nettype wire

FILE: rtl/core/lrs_checker.sv
// Port-level checker for line_raster_stepper_core, bound to every instance.
// Depends on lrs_pkg and line_raster_stepper_core_assert.svh.
`default_nettype none
`include "line_raster_stepper_core_assert.svh"

module lrs_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire lrs_pkg::t_in_item  i_item,
    input  wire logic               o_stall,
    input  wire logic               o_valid,
    input  wire lrs_pkg::t_out_item o_item,
    input  wire logic               i_stall
);

    logic load_acc;
    logic next_acc;

    assign load_acc = i_valid && !o_stall && (i_item.op == lrs_pkg::OP_LOAD);
    assign next_acc = i_valid && !o_stall && (i_item.op == lrs_pkg::OP_NEXT);

    `LRS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_item))
    `LRS_ASSERT_NOW(a_stall_backs_up, o_valid && i_stall, o_stall)
    `LRS_ASSERT_NEXT(a_load_no_cell, load_acc, o_valid && !o_item.point_valid && !o_item.last_point)
    `LRS_ASSERT_NEXT(a_next_no_count, next_acc, o_valid && (o_item.cell_count == '0))

endmodule

bind line_raster_stepper_core lrs_checker u_lrs_checker (.*);

`default_nettype wire
